// ===== rtl/ppsb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsb_pkg
// Shared types and constants for the parallel port to SPI bridge core.
// ----------------------------------------------------------------------------
package ppsb_pkg;

	localparam int unsigned InTdataW  = 24;
	localparam int unsigned OutTdataW = 24;
	localparam int unsigned CountW    = 13;
	localparam int unsigned CfgW      = 16;
	localparam int unsigned PhaseW    = 4;

	localparam logic [7:0]  CmdCtrlMask   = 8'hc0;
	localparam logic [7:0]  CmdLongBit    = 8'h80;
	localparam logic [7:0]  CmdReadBit    = 8'h40;
	localparam logic [7:0]  CmdShortCnt   = 8'h3f;
	localparam logic [7:0]  CmdLowCnt     = 8'h7f;
	localparam logic [7:0]  CmdSubMask    = 8'h3e;
	localparam logic [7:0]  PrefetchByte  = 8'hff;
	localparam logic [15:0] DebounceReset = 16'd50;

	// control command sub codes
	localparam logic [4:0] SubSelect  = 5'd0;
	localparam logic [4:0] SubPresent = 5'd1;
	localparam logic [4:0] SubFast    = 5'd2;

	typedef struct packed {
		logic [2:0] pad;
		logic       ms_tick;
		logic [7:0] spi_rx_byte;
		logic       spi_rx_valid;
		logic       card_detect_n;
		logic [7:0] port_data;
		logic       port_clk;
		logic       req_n;
	} in_item_t;

	typedef struct packed {
		logic [1:0] pad;
		logic       busy_res;
		logic       irq_pulse;
		logic       fast_clock;
		logic       select_n;
		logic       port_data_drive;
		logic [7:0] port_data_out;
		logic [7:0] spi_tx_byte;
		logic       spi_tx_valid;
	} out_item_t;

endpackage

// ===== rtl/parallel_port_to_spi_bridge_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_port_to_spi_bridge_core
// Per-cycle pin sample in, per-cycle bridge result out.
// ----------------------------------------------------------------------------
// A sample is taken into the input register, then its result into the
// result register; both stages hold while m_tready stalls the output.
// Throughput: one sample per cycle unless stalled; one-pass state update.
// Reset (arst_n low): phase idle, select high, detect enabled, timer zero,
// debounce_ms 50, both stream stages empty.
module parallel_port_to_spi_bridge_core #(
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// req_n, port_clk, port_data[7:0], card_detect_n, spi_rx_valid,
	// spi_rx_byte[7:0], ms_tick, zero pad
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// spi_tx_valid, spi_tx_byte[7:0], port_data_out[7:0], port_data_drive,
	// select_n, fast_clock, irq_pulse, busy_res, zero pad
	output logic [23:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int unsigned CmpW = (TIMER_WIDTH > ppsb_pkg::CfgW) ?
		TIMER_WIDTH : ppsb_pkg::CfgW;
	localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

	localparam logic [ppsb_pkg::PhaseW-1:0] PH_IDLE    = 4'd0;
	localparam logic [ppsb_pkg::PhaseW-1:0] PH_SECOND  = 4'd1;
	localparam logic [ppsb_pkg::PhaseW-1:0] PH_RD_RX   = 4'd2;
	localparam logic [ppsb_pkg::PhaseW-1:0] PH_RD_CLK  = 4'd3;
	localparam logic [ppsb_pkg::PhaseW-1:0] PH_WR_CLK  = 4'd4;
	localparam logic [ppsb_pkg::PhaseW-1:0] PH_WR_RX   = 4'd5;
	localparam logic [ppsb_pkg::PhaseW-1:0] PH_PRESENT = 4'd6;
	localparam logic [ppsb_pkg::PhaseW-1:0] PH_DONE    = 4'd7;

	// stream stages
	logic                 v_s1;
	ppsb_pkg::in_item_t   in_s1;
	logic                 out_valid_q;
	ppsb_pkg::out_item_t  out_q;
	logic                 adv;

	// bridge state
	logic [ppsb_pkg::PhaseW-1:0]  phase_q, phase_d;
	logic [ppsb_pkg::CountW-1:0]  count_q, count_d;
	logic                         last_clk_q, last_clk_d;
	logic                         last_req_q;
	logic                         read_dir_q, read_dir_d;
	logic [7:0]                   held_rx_q, held_rx_d;
	logic [7:0]                   data_out_q, data_out_d;
	logic                         drive_q, drive_d;
	logic                         select_q, select_d;
	logic                         fast_q, fast_d;
	logic                         detect_en_q, detect_en_d;
	logic                         last_detect_q;
	logic [TIMER_WIDTH-1:0]       timer_q, timer_d;
	logic [ppsb_pkg::CfgW-1:0]    debounce_q;

	logic       req, pclk, fall, rise, toggled, tx_v, irq;
	logic [7:0] d, tx_b;
	logic [4:0] sub;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !v_s1 || adv;
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	assign req     = in_s1.req_n;
	assign pclk    = in_s1.port_clk;
	assign d       = in_s1.port_data;
	assign fall    = last_req_q && !req;
	assign rise    = !last_req_q && req;
	assign toggled = pclk != last_clk_q;
	assign sub     = 5'((d & ppsb_pkg::CmdSubMask) >> 1);

	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		last_clk_d  = last_clk_q;
		read_dir_d  = read_dir_q;
		held_rx_d   = held_rx_q;
		data_out_d  = data_out_q;
		drive_d     = drive_q;
		select_d    = select_q;
		fast_d      = fast_q;
		tx_v        = 1'b0;
		tx_b        = 8'h00;
		case (phase_q)
			PH_SECOND: begin
				if (toggled) begin
					last_clk_d = pclk;
					read_dir_d = d[7];
					count_d    = count_q | ppsb_pkg::CountW'(d & ppsb_pkg::CmdLowCnt);
					if (d[7]) begin
						tx_v    = 1'b1;
						tx_b    = ppsb_pkg::PrefetchByte;
						phase_d = PH_RD_RX;
					end else begin
						phase_d = PH_WR_CLK;
					end
				end else if (req) begin
					phase_d = PH_IDLE; data_out_d = 8'h00; drive_d = 1'b0;
				end
			end
			PH_RD_RX: begin
				if (in_s1.spi_rx_valid) begin
					held_rx_d = in_s1.spi_rx_byte;
					phase_d   = PH_RD_CLK;
				end else if (req) begin
					phase_d = PH_IDLE; data_out_d = 8'h00; drive_d = 1'b0;
				end
			end
			PH_RD_CLK: begin
				if (toggled) begin
					data_out_d = held_rx_q;
					drive_d    = 1'b1;
					if (count_q == '0) begin
						phase_d = PH_DONE;
					end else begin
						tx_v       = 1'b1;
						tx_b       = ppsb_pkg::PrefetchByte;
						last_clk_d = pclk;
						count_d    = count_q - 1'b1;
						phase_d    = PH_RD_RX;
					end
				end else if (req) begin
					phase_d = PH_IDLE; data_out_d = 8'h00; drive_d = 1'b0;
				end
			end
			PH_WR_CLK: begin
				if (toggled) begin
					tx_v       = 1'b1;
					tx_b       = d;
					last_clk_d = pclk;
					phase_d    = PH_WR_RX;
				end else if (req) begin
					phase_d = PH_IDLE; data_out_d = 8'h00; drive_d = 1'b0;
				end
			end
			PH_WR_RX: begin
				if (in_s1.spi_rx_valid) begin
					if (count_q == '0) begin
						phase_d = PH_DONE;
					end else begin
						count_d = count_q - 1'b1;
						phase_d = PH_WR_CLK;
					end
				end else if (req) begin
					phase_d = PH_IDLE; data_out_d = 8'h00; drive_d = 1'b0;
				end
			end
			PH_PRESENT: begin
				if (toggled) begin
					last_clk_d = pclk;
					data_out_d = {7'd0, !in_s1.card_detect_n};
					drive_d    = 1'b1;
					phase_d    = PH_DONE;
				end else if (req) begin
					phase_d = PH_IDLE; data_out_d = 8'h00; drive_d = 1'b0;
				end
			end
			PH_DONE: begin
				if (req) begin
					phase_d = PH_IDLE; data_out_d = 8'h00; drive_d = 1'b0;
				end
			end
			default: begin
				// idle, and any unused phase code falls back here
				phase_d = PH_IDLE;
				if (fall) begin
					last_clk_d = pclk;
					if ((d & ppsb_pkg::CmdCtrlMask) != ppsb_pkg::CmdCtrlMask) begin
						if ((d & ppsb_pkg::CmdLongBit) == 8'h00) begin
							read_dir_d = (d & ppsb_pkg::CmdReadBit) != 8'h00;
							count_d    = ppsb_pkg::CountW'(d & ppsb_pkg::CmdShortCnt);
							if ((d & ppsb_pkg::CmdReadBit) != 8'h00) begin
								tx_v    = 1'b1;
								tx_b    = ppsb_pkg::PrefetchByte;
								phase_d = PH_RD_RX;
							end else begin
								phase_d = PH_WR_CLK;
							end
						end else begin
							// high count bits now, low bits with the second byte
							count_d = {d[5:0], 7'd0};
							phase_d = PH_SECOND;
						end
					end else begin
						phase_d = PH_DONE;
						case (sub)
							ppsb_pkg::SubSelect:  select_d = !d[0];
							ppsb_pkg::SubPresent: phase_d  = PH_PRESENT;
							ppsb_pkg::SubFast:    fast_d   = d[0];
							default: ;
						endcase
					end
				end
			end
		endcase
	end

	// card detect gating and debounce timer
	always_comb begin
		detect_en_d = detect_en_q;
		if (fall)
			detect_en_d = 1'b0;
		if (rise)
			detect_en_d = 1'b1;
		irq     = (in_s1.card_detect_n != last_detect_q) && detect_en_d &&
			(CmpW'(timer_q) >= CmpW'(debounce_q));
		timer_d = timer_q;
		if (irq)
			timer_d = '0;
		else if (in_s1.ms_tick && timer_q != TimerMax)
			timer_d = timer_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= ppsb_pkg::DebounceReset;
		end else if (cfg_valid) begin
			debounce_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			in_s1 <= s_tdata;
	end

	// advance the sample in stage one into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			phase_q       <= PH_IDLE;
			count_q       <= '0;
			last_clk_q    <= 1'b0;
			last_req_q    <= 1'b1;
			read_dir_q    <= 1'b0;
			held_rx_q     <= 8'h00;
			data_out_q    <= 8'h00;
			drive_q       <= 1'b0;
			select_q      <= 1'b1;
			fast_q        <= 1'b0;
			detect_en_q   <= 1'b1;
			last_detect_q <= 1'b1;
			timer_q       <= '0;
		end else if (adv) begin
			out_valid_q <= v_s1;
			if (v_s1) begin
				phase_q       <= phase_d;
				count_q       <= count_d;
				last_clk_q    <= last_clk_d;
				last_req_q    <= req;
				read_dir_q    <= read_dir_d;
				held_rx_q     <= held_rx_d;
				data_out_q    <= data_out_d;
				drive_q       <= drive_d;
				select_q      <= select_d;
				fast_q        <= fast_d;
				detect_en_q   <= detect_en_d;
				last_detect_q <= in_s1.card_detect_n;
				timer_q       <= timer_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			out_q.pad             <= '0;
			out_q.busy_res        <= phase_d != PH_IDLE;
			out_q.irq_pulse       <= irq;
			out_q.fast_clock      <= fast_d;
			out_q.select_n        <= select_d;
			out_q.port_data_drive <= drive_d;
			out_q.port_data_out   <= data_out_d;
			out_q.spi_tx_byte     <= tx_b;
			out_q.spi_tx_valid    <= tx_v;
		end
	end

endmodule

// ===== bench/parallel_port_to_spi_bridge_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_port_to_spi_bridge_core_test
// Self-checking bench for the parallel port to SPI bridge core. Per-cycle pin
// samples go in on the slave stream and are also run through a local model
// of the bridge. Each sample queues one expected result, and every result on
// the master stream is compared field by field against the oldest one. A
// short directed table comes first. Random host sessions follow, under
// several debounce settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module parallel_port_to_spi_bridge_core_test;

	localparam int unsigned CycleLimit = 400000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CNT_LO,
		ST_RD_WAIT,
		ST_RD_TOG,
		ST_WR_TOG,
		ST_WR_WAIT,
		ST_PRESENCE,
		ST_HOLD
	} bridge_state_t;

	typedef struct packed {
		ppsb_pkg::in_item_t  stim;
		logic                typed;
		ppsb_pkg::out_item_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// bridge model state
	bridge_state_t br_state = ST_IDLE;
	logic [12:0]   bytes_left = '0;
	logic          clk_seen = 1'b0;
	logic          req_seen = 1'b1;
	logic          is_read = 1'b0;
	logic [7:0]    rx_hold = '0;
	logic [7:0]    pins_out = '0;
	logic          pins_drive = 1'b0;
	logic          sel_n = 1'b1;
	logic          fast_sel = 1'b0;
	logic          cd_armed = 1'b1;
	logic          cd_seen = 1'b1;
	logic [15:0]   cd_timer = '0;
	logic [15:0]   debounce_set = ppsb_pkg::DebounceReset;

	ppsb_pkg::out_item_t pin_results_q[$];
	plan_row_t           plan_q[$];
	int unsigned samples_sent = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int          stall_left = 0;
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	logic        cd_pin = 1'b1;

	parallel_port_to_spi_bridge_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic ppsb_pkg::in_item_t pins(input logic req, input logic pclk,
			input logic [7:0] d, input logic cd, input logic rxv, input logic [7:0] rxb,
			input logic tick);
		ppsb_pkg::in_item_t s;
		s = '0;
		s.req_n = req;
		s.port_clk = pclk;
		s.port_data = d;
		s.card_detect_n = cd;
		s.spi_rx_valid = rxv;
		s.spi_rx_byte = rxb;
		s.ms_tick = tick;
		return s;
	endfunction

	function automatic ppsb_pkg::out_item_t outs(input logic txv, input logic [7:0] txb,
			input logic [7:0] dout, input logic drv, input logic sel, input logic fast,
			input logic irq, input logic busy);
		ppsb_pkg::out_item_t r;
		r = '0;
		r.spi_tx_valid = txv;
		r.spi_tx_byte = txb;
		r.port_data_out = dout;
		r.port_data_drive = drv;
		r.select_n = sel;
		r.fast_clock = fast;
		r.irq_pulse = irq;
		r.busy_res = busy;
		return r;
	endfunction

	function automatic plan_row_t plan_row(input ppsb_pkg::in_item_t s, input logic t,
			input ppsb_pkg::out_item_t w);
		plan_row_t r;
		r.stim = s;
		r.typed = t;
		r.want = w;
		return r;
	endfunction

	task automatic release_port();
		br_state = ST_IDLE;
		pins_out = '0;
		pins_drive = 1'b0;
	endtask

	// advance the bridge model by one pin sample
	task automatic bridge_step(input ppsb_pkg::in_item_t smp, output ppsb_pkg::out_item_t res);
		logic       fall, rise, toggled, tx_v, irq;
		logic [7:0] d, tx_b;
		logic [4:0] sub;
		d = smp.port_data;
		fall = req_seen && !smp.req_n;
		rise = !req_seen && smp.req_n;
		toggled = smp.port_clk != clk_seen;
		tx_v = 1'b0;
		tx_b = '0;
		irq = 1'b0;
		case (br_state)
			ST_CNT_LO: begin
				if (toggled) begin
					clk_seen = smp.port_clk;
					is_read = (d & ppsb_pkg::CmdLongBit) != 8'h00;
					bytes_left = bytes_left | 13'(d & ppsb_pkg::CmdLowCnt);
					if (is_read) begin
						tx_v = 1'b1;
						tx_b = ppsb_pkg::PrefetchByte;
						br_state = ST_RD_WAIT;
					end else begin
						br_state = ST_WR_TOG;
					end
				end else if (smp.req_n) begin
					release_port();
				end
			end
			ST_RD_WAIT: begin
				if (smp.spi_rx_valid) begin
					rx_hold = smp.spi_rx_byte;
					br_state = ST_RD_TOG;
				end else if (smp.req_n) begin
					release_port();
				end
			end
			ST_RD_TOG: begin
				if (toggled) begin
					pins_out = rx_hold;
					pins_drive = 1'b1;
					// the last byte leaves the clock level unconsumed
					if (bytes_left == '0) begin
						br_state = ST_HOLD;
					end else begin
						tx_v = 1'b1;
						tx_b = ppsb_pkg::PrefetchByte;
						clk_seen = smp.port_clk;
						bytes_left = bytes_left - 13'd1;
						br_state = ST_RD_WAIT;
					end
				end else if (smp.req_n) begin
					release_port();
				end
			end
			ST_WR_TOG: begin
				if (toggled) begin
					tx_v = 1'b1;
					tx_b = d;
					clk_seen = smp.port_clk;
					br_state = ST_WR_WAIT;
				end else if (smp.req_n) begin
					release_port();
				end
			end
			ST_WR_WAIT: begin
				if (smp.spi_rx_valid) begin
					if (bytes_left == '0) begin
						br_state = ST_HOLD;
					end else begin
						bytes_left = bytes_left - 13'd1;
						br_state = ST_WR_TOG;
					end
				end else if (smp.req_n) begin
					release_port();
				end
			end
			ST_PRESENCE: begin
				if (toggled) begin
					clk_seen = smp.port_clk;
					pins_out = smp.card_detect_n ? 8'd0 : 8'd1;
					pins_drive = 1'b1;
					br_state = ST_HOLD;
				end else if (smp.req_n) begin
					release_port();
				end
			end
			ST_HOLD: begin
				if (smp.req_n)
					release_port();
			end
			default: begin
				br_state = ST_IDLE;
				if (fall) begin
					clk_seen = smp.port_clk;
					if ((d & ppsb_pkg::CmdCtrlMask) != ppsb_pkg::CmdCtrlMask) begin
						if ((d & ppsb_pkg::CmdLongBit) == 8'h00) begin
							is_read = (d & ppsb_pkg::CmdReadBit) != 8'h00;
							bytes_left = 13'(d & ppsb_pkg::CmdShortCnt);
							if (is_read) begin
								tx_v = 1'b1;
								tx_b = ppsb_pkg::PrefetchByte;
								br_state = ST_RD_WAIT;
							end else begin
								br_state = ST_WR_TOG;
							end
						end else begin
							bytes_left = 13'(d & ppsb_pkg::CmdShortCnt) << 7;
							br_state = ST_CNT_LO;
						end
					end else begin
						sub = 5'((d & ppsb_pkg::CmdSubMask) >> 1);
						br_state = ST_HOLD;
						if (sub == ppsb_pkg::SubSelect)
							sel_n = !d[0];
						else if (sub == ppsb_pkg::SubPresent)
							br_state = ST_PRESENCE;
						else if (sub == ppsb_pkg::SubFast)
							fast_sel = d[0];
					end
				end
			end
		endcase
		req_seen = smp.req_n;

		if (fall)
			cd_armed = 1'b0;
		if (rise)
			cd_armed = 1'b1;
		if (smp.card_detect_n != cd_seen && cd_armed && cd_timer >= debounce_set) begin
			irq = 1'b1;
			cd_timer = '0;
		end else if (smp.ms_tick && cd_timer != 16'hffff) begin
			cd_timer = cd_timer + 16'd1;
		end
		cd_seen = smp.card_detect_n;

		res = outs(tx_v, tx_b, pins_out, pins_drive, sel_n, fast_sel, irq,
			br_state != ST_IDLE);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] result %0d %s: got %0h, want %0h", $time, results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(input ppsb_pkg::out_item_t got);
		ppsb_pkg::out_item_t want;
		if (pin_results_q.size() == 0) begin
			report_mismatch("unexpected transaction", got, 0);
			return;
		end
		want = pin_results_q.pop_front();
		if (got.spi_tx_valid !== want.spi_tx_valid)
			report_mismatch("spi_tx_valid", got.spi_tx_valid, want.spi_tx_valid);
		if (got.spi_tx_byte !== want.spi_tx_byte)
			report_mismatch("spi_tx_byte", got.spi_tx_byte, want.spi_tx_byte);
		if (got.port_data_out !== want.port_data_out)
			report_mismatch("port_data_out", got.port_data_out, want.port_data_out);
		if (got.port_data_drive !== want.port_data_drive)
			report_mismatch("port_data_drive", got.port_data_drive, want.port_data_drive);
		if (got.select_n !== want.select_n)
			report_mismatch("select_n", got.select_n, want.select_n);
		if (got.fast_clock !== want.fast_clock)
			report_mismatch("fast_clock", got.fast_clock, want.fast_clock);
		if (got.irq_pulse !== want.irq_pulse)
			report_mismatch("irq_pulse", got.irq_pulse, want.irq_pulse);
		if (got.busy_res !== want.busy_res)
			report_mismatch("busy_res", got.busy_res, want.busy_res);
		results_seen++;
	endtask

	// hold valid until the transaction is taken, then queue its result
	task automatic send_sample(input ppsb_pkg::in_item_t smp, input logic typed,
			input ppsb_pkg::out_item_t want);
		ppsb_pkg::out_item_t res;
		if (tx_idle && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bridge_step(smp, res);
		pin_results_q.push_back(typed ? want : res);
		samples_sent++;
	endtask

	function automatic ppsb_pkg::in_item_t host_noise();
		if ($urandom_range(0, 9) == 0)
			cd_pin = !cd_pin;
		return pins(1'b1, clk_seen, 8'($urandom), cd_pin, $urandom_range(0, 7) == 0,
			8'($urandom), 1'($urandom));
	endfunction

	function automatic logic [7:0] small_count(input int unsigned bits);
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, (1 << bits) - 1));
		return 8'($urandom_range(0, 3));
	endfunction

	task automatic host_session();
		ppsb_pkg::in_item_t smp;
		logic [7:0]         cmd;
		logic [4:0]         sub;
		int unsigned        kind, budget;
		if (!req_seen)
			send_sample(host_noise(), 1'b0, '0);
		kind = $urandom_range(0, 99);
		if (kind >= 90) begin
			// garbage on every line
			repeat ($urandom_range(3, 12)) begin
				smp = host_noise();
				smp.req_n = 1'($urandom);
				smp.port_clk = 1'($urandom);
				smp.spi_rx_valid = 1'($urandom);
				send_sample(smp, 1'b0, '0);
			end
			return;
		end
		if (kind < 30) begin
			cmd = {2'b00, 6'(small_count(6))};
		end else if (kind < 55) begin
			cmd = {2'b01, 6'(small_count(6))};
		end else if (kind < 70) begin
			cmd = {2'b10, ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'd0};
		end else begin
			case ($urandom_range(0, 3))
				0: sub = ppsb_pkg::SubSelect;
				1: sub = ppsb_pkg::SubPresent;
				2: sub = ppsb_pkg::SubFast;
				default: sub = 5'($urandom);
			endcase
			cmd = {2'b11, sub, 1'($urandom)};
		end
		smp = host_noise();
		smp.req_n = 1'b0;
		smp.port_data = cmd;
		smp.port_clk = 1'($urandom);
		send_sample(smp, 1'b0, '0);

		budget = $urandom_range(2, 40);
		while (budget > 0 && br_state != ST_IDLE && br_state != ST_HOLD) begin
			smp = host_noise();
			smp.req_n = 1'b0;
			smp.spi_rx_valid = 1'b0;
			case (br_state)
				ST_CNT_LO, ST_RD_TOG, ST_WR_TOG, ST_PRESENCE: begin
					if ($urandom_range(0, 3) != 0)
						smp.port_clk = !clk_seen;
					if (br_state == ST_CNT_LO)
						smp.port_data = {1'($urandom), 7'(small_count(7))};
				end
				ST_RD_WAIT, ST_WR_WAIT: smp.spi_rx_valid = $urandom_range(0, 2) != 0;
				default: ;
			endcase
			send_sample(smp, 1'b0, '0);
			budget--;
		end
		repeat ($urandom_range(0, 2)) begin
			smp = host_noise();
			smp.req_n = 1'b0;
			send_sample(smp, 1'b0, '0);
		end
		// end or abort the request; a toggle may ride along with it
		smp = host_noise();
		smp.port_clk = 1'($urandom);
		send_sample(smp, 1'b0, '0);
		repeat ($urandom_range(0, 5)) begin
			smp = host_noise();
			smp.ms_tick = $urandom_range(0, 3) != 0;
			send_sample(smp, 1'b0, '0);
		end
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned goal;
		goal = samples_sent + count;
		while (samples_sent < goal)
			host_session();
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pin_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_debounce(input logic [15:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		debounce_set = value;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(ppsb_pkg::out_item_t'(m_tdata));
			if (stall_left > 0) begin
				stall_left = stall_left - 1;
				m_tready <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("parallel_port_to_spi_bridge_core_test: done, errors");
			$finish;
		end
	end

	initial begin
		// request, clock, data, detect, rx valid, rx byte, tick
		plan_q.push_back(plan_row(pins(1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0), 1'b1,
			outs(1'b0, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0)));
		plan_q.push_back(plan_row(pins(1'b0, 1'b0, 8'hc1, 1'b1, 1'b0, 8'h00, 1'b0), 1'b1,
			outs(1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1)));
		plan_q.push_back(plan_row(pins(1'b1, 1'b0, 8'hc1, 1'b1, 1'b0, 8'h00, 1'b0), 1'b1,
			outs(1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)));
		plan_q.push_back(plan_row(pins(1'b0, 1'b0, 8'hc5, 1'b1, 1'b0, 8'h00, 1'b0), 1'b1,
			outs(1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1)));
		plan_q.push_back(plan_row(pins(1'b1, 1'b0, 8'hc5, 1'b1, 1'b0, 8'h00, 1'b0), 1'b1,
			outs(1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)));
		// presence query, card inserted meanwhile
		plan_q.push_back(plan_row(pins(1'b0, 1'b0, 8'hc2, 1'b1, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		// two-byte write
		plan_q.push_back(plan_row(pins(1'b0, 1'b1, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b0, 1'b0, 8'ha5, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b0, 1'b0, 8'ha5, 1'b0, 1'b1, 8'h33, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b0, 1'b1, 8'h5a, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b0, 1'b1, 8'h5a, 1'b0, 1'b1, 8'hcc, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		// longest short read, aborted while waiting on the SPI side
		plan_q.push_back(plan_row(pins(1'b0, 1'b1, 8'h7f, 1'b0, 1'b0, 8'h00, 1'b0), 1'b1,
			outs(1'b1, ppsb_pkg::PrefetchByte, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1)));
		plan_q.push_back(plan_row(pins(1'b0, 1'b1, 8'h7f, 1'b0, 1'b1, 8'h3c, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0), 1'b1,
			outs(1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)));
		// stray SPI byte while idle
		plan_q.push_back(plan_row(pins(1'b1, 1'b0, 8'hff, 1'b0, 1'b1, 8'hff, 1'b0), 1'b1,
			outs(1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0)));
		// long read with the largest count, toggle and rising request together
		plan_q.push_back(plan_row(pins(1'b0, 1'b0, 8'hbf, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b0, 1'b1, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b0, 1'b1, 8'hff, 1'b0, 1'b1, 8'h00, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b1, 1'b0, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		plan_q.push_back(plan_row(pins(1'b1, 1'b0, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, '0));
		// unknown control code
		plan_q.push_back(plan_row(pins(1'b0, 1'b0, 8'hfe, 1'b0, 1'b1, 8'h55, 1'b0), 1'b0, '0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_q[i])
			send_sample(plan_q[i].stim, plan_q[i].typed, plan_q[i].want);
		cd_pin = 1'b0;

		run_random(100);
		set_debounce(16'd0);
		run_random(115);
		set_debounce(16'hffff);
		run_random(70);
		set_debounce(16'($urandom_range(1, 6)));
		run_random(60);
		// let everything drain before carrying on
		wait_drained();
		run_random(50);
		set_debounce(16'd3);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		run_random(90);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pin_results_q.size() == 0)
			$display("parallel_port_to_spi_bridge_core_test: done, clean");
		else
			$display("parallel_port_to_spi_bridge_core_test: done, errors");
		$finish;
	end

endmodule
